### rtl/lrs_pkg.sv
// Shared types, constants and the sigmoid lookup table for the logistic
// regression SGD block. No dependencies; used by lrs_mul and the top level.
`timescale 1ns / 1ps

package lrs_pkg;

  // Number of weights and buffered features per instance
  localparam int FEATURES   = 16;
  localparam int FEAT_IDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int FEAT_CNT_W = $clog2(FEATURES + 1);

  // Dot-product accumulator: 48-bit products plus growth over FEATURES terms
  localparam int ACC_W = 48 + FEAT_IDX_W + 1;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Weight update rounds the Q.52 step down to Q.24
  localparam int DELTA_SHIFT = 28;

  // Function codes of an input item
  localparam logic [1:0] FUNC_TRAIN    = 2'd0;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd1;
  localparam logic [1:0] FUNC_READ     = 2'd2;

  // Register map
  localparam logic [1:0]  ADDR_LEARNING_RATE  = 2'd0;
  localparam logic [23:0] LEARNING_RATE_RESET = 24'd1678;

  // exp(-1/16) in Q0.32
  localparam logic [31:0] SIG_STEP_Q = 32'd4034748382;

  typedef logic [255:0][15:0] sig_table_t;

  // Builds the sigmoid table at elaboration: entry i is sigmoid((i-128)/16)
  // in Q0.16. The quotient is formed by shift-and-subtract long division.
  function automatic sig_table_t sig_table_build();
    sig_table_t  tbl;
    logic [65:0] e;
    logic [33:0] den;
    logic [48:0] num;
    logic [48:0] quo;
    logic [34:0] rem;
    tbl = '0;
    e   = 66'(1) << 32;
    for (int m = 0; m <= 128; m++) begin
      if (m > 0) begin
        e = (e * 66'(SIG_STEP_Q) + (66'(1) << 31)) >> 32;
      end
      den = 34'(e) + (34'(1) << 32);
      num = (49'(1) << 48) + 49'(den >> 1);
      rem = '0;
      quo = '0;
      for (int k = 48; k >= 0; k--) begin
        rem = {rem[33:0], num[k]};
        quo = {quo[47:0], 1'b0};
        if (rem >= 35'(den)) begin
          rem    = rem - 35'(den);
          quo[0] = 1'b1;
        end
      end
      if (m < 128) begin
        tbl[128 + m] = quo[15:0];
      end
      if (m > 0) begin
        tbl[128 - m] = 16'(17'h10000 - quo[16:0]);
      end
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_table_build();

endpackage

### rtl/lrs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on lrs_pkg for the operand and product widths.
`timescale 1ns / 1ps

module lrs_mul (
  input  logic                                 clk,
  input  logic signed [lrs_pkg::MUL_A_W-1:0]   a,
  input  logic signed [lrs_pkg::MUL_B_W-1:0]   b,
  output logic signed [lrs_pkg::MUL_P_W-1:0]   p
);

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    p <= lrs_pkg::MUL_P_W'(a * b);
  end

endmodule

### rtl/logistic_regression_sgd_step.sv
// Online logistic regression: one SGD step per training instance.
// Uses lrs_pkg and the shared multiplier lrs_mul.
`timescale 1ns / 1ps

// Features stream in one per transfer and are buffered; a feature that does not
// close its instance leaves the block ready for the next. The closing feature
// starts a sequencer that runs everything through one registered multiplier,
// with a multiply and an accumulate or add state per buffered feature per pass:
// a classify-only instance gets the dot-product pass and sigmoid lookup, a
// training one also step scaling and the weight update pass. A weight read
// registers the weight first. The probability comes from a 256-entry table over
// the logit clamped to [-8,8). Weights are Q8.24 and saturate; they reset to
// zero. Results sit in an output register, so the next feature can be taken
// while a result waits. learning_rate lives at APB byte address 0.

module logistic_regression_sgd_step (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         func,
  input  logic signed [15:0] feature,
  input  logic               label,
  input  logic               last,
  input  logic [3:0]         weight_index,
  // result items
  output logic               result_valid,
  input  logic               result_ready,
  output logic [15:0]        probability,
  output logic signed [31:0] weight_value,
  output logic               too_many_features,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = lrs_pkg::FEAT_IDX_W;
  localparam int CNT_W = lrs_pkg::FEAT_CNT_W;
  localparam int ACC_W = lrs_pkg::ACC_W;
  localparam int A_W   = lrs_pkg::MUL_A_W;
  localparam int B_W   = lrs_pkg::MUL_B_W;
  localparam int P_W   = lrs_pkg::MUL_P_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DOT_MUL,
    S_DOT_ACC,
    S_SIG,
    S_RATE_MUL,
    S_RATE_CAP,
    S_UPD_MUL,
    S_UPD_ADD,
    S_RESP
  } state_t;

  state_t                    state;
  logic [23:0]               learning_rate;
  logic signed [31:0]        weight_store [lrs_pkg::FEATURES];
  logic signed [15:0]        feature_buffer [lrs_pkg::FEATURES];
  logic [CNT_W-1:0]          feature_count;
  logic                      overflow_seen;
  logic [CNT_W-1:0]          idx;
  logic                      train_mode;
  logic                      label_r;
  logic                      is_read;
  logic                      read_ok;
  logic signed [ACC_W-1:0]   acc;
  logic [15:0]               p_reg;
  logic signed [A_W-1:0]     scaled;
  logic signed [31:0]        read_val;

  logic                      item_xfer;
  logic                      is_feature;
  logic                      has_room;
  logic [IDX_W-1:0]          idx_sel;
  logic [IDX_W-1:0]          cnt_sel;
  logic [CNT_W-1:0]          idx_inc;
  logic                      idx_done;
  logic signed [31:0]        w_cur;
  logic signed [15:0]        x_cur;
  logic signed [B_W-1:0]     err;
  logic signed [A_W-1:0]     mul_a;
  logic signed [B_W-1:0]     mul_b;
  logic signed [P_W-1:0]     mul_p;
  logic [P_W-1:0]            rounded;
  logic signed [31:0]        delta;
  logic signed [32:0]        w_sum;
  logic signed [31:0]        w_sat;
  logic                      logit_low;
  logic                      logit_high;
  logic [7:0]                sig_idx;
  logic                      cfg_write;

  // Handshake and index helpers
  assign item_ready = (state == S_IDLE);
  assign item_xfer  = item_valid && item_ready;
  assign is_feature = func inside {lrs_pkg::FUNC_TRAIN, lrs_pkg::FUNC_CLASSIFY};
  assign has_room   = feature_count < CNT_W'(lrs_pkg::FEATURES);
  assign idx_sel    = idx[IDX_W-1:0];
  assign cnt_sel    = feature_count[IDX_W-1:0];
  assign idx_inc    = idx + CNT_W'(1);
  assign idx_done   = (idx_inc == feature_count);
  assign w_cur      = weight_store[idx_sel];
  assign x_cur      = feature_buffer[idx_sel];

  // Prediction error label - p, Q0.16 in 18 bits
  assign err = signed'({1'b0, label_r, 16'b0}) - signed'({2'b00, p_reg});

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DOT_MUL: begin
        mul_a = A_W'(w_cur);
        mul_b = B_W'(x_cur);
      end
      S_RATE_MUL: begin
        mul_a = signed'(A_W'(learning_rate));
        mul_b = err;
      end
      S_UPD_MUL: begin
        mul_a = scaled;
        mul_b = B_W'(x_cur);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lrs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Weight update: round step half up to Q.24, add, saturate
  assign rounded = mul_p + (P_W'(1) << (lrs_pkg::DELTA_SHIFT - 1));
  assign delta   = signed'(rounded[lrs_pkg::DELTA_SHIFT +: 32]);
  assign w_sum   = {w_cur[31], w_cur} + {delta[31], delta};

  always_comb begin
    if (w_sum[32] != w_sum[31]) begin
      w_sat = w_sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      w_sat = w_sum[31:0];
    end
  end

  // Logit clamp to [-8,8) in Q.36 and table index
  assign logit_low  = acc[ACC_W-1] && !(&acc[ACC_W-2:39]);
  assign logit_high = !acc[ACC_W-1] && (|acc[ACC_W-2:39]);

  always_comb begin
    if (logit_low) begin
      sig_idx = 8'd0;
    end else if (logit_high) begin
      sig_idx = 8'd255;
    end else begin
      sig_idx = {~acc[39], acc[38:32]};
    end
  end

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == lrs_pkg::ADDR_LEARNING_RATE);
  assign prdata    = (paddr == lrs_pkg::ADDR_LEARNING_RATE) ? {8'b0, learning_rate} : 32'b0;

  // Feature buffer: written as features arrive
  always_ff @(posedge clk) begin
    if (item_xfer && is_feature && has_room) begin
      feature_buffer[cnt_sel] <= feature;
    end
  end

  // Sequencer, weights and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      learning_rate     <= lrs_pkg::LEARNING_RATE_RESET;
      for (int i = 0; i < lrs_pkg::FEATURES; i++) begin
        weight_store[i] <= '0;
      end
      feature_count     <= '0;
      overflow_seen     <= 1'b0;
      idx               <= '0;
      train_mode        <= 1'b0;
      label_r           <= 1'b0;
      is_read           <= 1'b0;
      read_ok           <= 1'b0;
      acc               <= '0;
      p_reg             <= '0;
      scaled            <= '0;
      read_val          <= '0;
      result_valid      <= 1'b0;
      probability       <= '0;
      weight_value      <= '0;
      too_many_features <= 1'b0;
    end else begin
      if (cfg_write) begin
        learning_rate <= pwdata[23:0];
      end

      // Output register empties on a result transfer unless refilled below
      if (result_valid && result_ready && state != S_RESP) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_xfer) begin
            if (is_feature) begin
              if (has_room) begin
                feature_count <= feature_count + CNT_W'(1);
              end else begin
                overflow_seen <= 1'b1;
              end
              if (last) begin
                train_mode <= (func == lrs_pkg::FUNC_TRAIN);
                label_r    <= label;
                is_read    <= 1'b0;
                idx        <= '0;
                acc        <= '0;
                state      <= S_DOT_MUL;
              end
            end else if (func == lrs_pkg::FUNC_READ) begin
              idx     <= CNT_W'(weight_index);
              read_ok <= 32'(weight_index) < lrs_pkg::FEATURES;
              is_read <= 1'b1;
              state   <= S_READ;
            end
          end
        end

        S_READ: begin
          read_val <= read_ok ? w_cur : 32'sd0;
          state    <= S_RESP;
        end

        // Dot product: each term is multiplied, then accumulated
        S_DOT_MUL: begin
          state <= S_DOT_ACC;
        end

        S_DOT_ACC: begin
          acc <= acc + signed'(mul_p[ACC_W-1:0]);
          idx <= idx_inc;
          state <= idx_done ? S_SIG : S_DOT_MUL;
        end

        S_SIG: begin
          p_reg <= lrs_pkg::SIG_TABLE[sig_idx];
          state <= train_mode ? S_RATE_MUL : S_RESP;
        end

        // rate * err, then the update pass
        S_RATE_MUL: begin
          state <= S_RATE_CAP;
        end

        S_RATE_CAP: begin
          scaled <= mul_p[A_W-1:0];
          idx    <= '0;
          state  <= S_UPD_MUL;
        end

        S_UPD_MUL: begin
          state <= S_UPD_ADD;
        end

        S_UPD_ADD: begin
          weight_store[idx_sel] <= w_sat;
          idx   <= idx_inc;
          state <= idx_done ? S_RESP : S_UPD_MUL;
        end

        // Hand the result to the output register once it is free
        S_RESP: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            if (is_read) begin
              probability       <= '0;
              weight_value      <= read_val;
              too_many_features <= 1'b0;
            end else begin
              probability       <= p_reg;
              weight_value      <= '0;
              too_many_features <= overflow_seen;
              feature_count     <= '0;
              overflow_seen     <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/lrs_checker.sv
// Watcher for the logistic regression SGD block: follows the item, result and
// APB channels, keeps its own weights and sigmoid table, and counts faults.
// Depends on lrs_pkg for the function codes, register address and FEATURES.
`timescale 1ns / 1ps

module lrs_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic [1:0]         func,
  input  logic signed [15:0] feature,
  input  logic               label,
  input  logic               last,
  input  logic [3:0]         weight_index,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic [15:0]        probability,
  input  logic signed [31:0] weight_value,
  input  logic               too_many_features,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 answers_owed
);

  // exp(-1/16) in Q0.32, logit clamp 8.0 in Q12.36, half an LSB of Q.24 in Q.52
  localparam longint unsigned EXP_STEP    = 64'd4034748382;
  localparam longint          LOGIT_CLAMP = 64'sd1 <<< 39;
  localparam longint          HALF_LSB    = 64'sd1 <<< 27;
  localparam longint          W_MAX       = 64'sd2147483647;
  localparam longint          W_MIN       = -64'sd2147483648;

  typedef struct packed {
    logic [15:0] prob;
    logic [31:0] wval;
    logic        flag;
  } answer_t;

  answer_t            owed_answers[$];
  logic [15:0]        sig_lut    [256];
  logic signed [31:0] weight_mem [lrs_pkg::FEATURES];
  logic signed [15:0] feat_buf   [lrs_pkg::FEATURES];
  int                 feat_count;
  logic               overflow;
  logic [23:0]        rate;
  int                 fault_count = 0;
  int                 owed_count  = 0;

  assign mismatches   = fault_count;
  assign answers_owed = owed_count;

  // Sigmoid table: upper half from 1/(1+e^-m/16), lower half by symmetry
  initial begin : sigmoid_lut
    longint unsigned e, den, s;
    e = 64'd1 << 32;
    for (int m = 0; m <= 128; m++) begin
      if (m > 0) begin
        e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
      end
      den = (64'd1 << 32) + e;
      s   = ((64'd1 << 48) + den / 2) / den;
      if (m < 128) begin
        sig_lut[128 + m] = 16'(s);
      end
      if (m > 0) begin
        sig_lut[128 - m] = 16'(64'd65536 - s);
      end
    end
  end

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%t %s", $realtime, msg);
    end
  endtask

  // One accepted item: buffer a feature, close an instance or read a weight
  task automatic run_sgd_step();
    longint      dot, err, scaled, delta, sum;
    int          idx;
    logic [15:0] p;
    answer_t     ans;
    case (func)
      lrs_pkg::FUNC_READ: begin
        ans.prob = '0;
        ans.flag = 1'b0;
        ans.wval = (int'(weight_index) < lrs_pkg::FEATURES) ?
                   weight_mem[weight_index] : '0;
        owed_answers = {owed_answers, ans};
      end
      lrs_pkg::FUNC_TRAIN, lrs_pkg::FUNC_CLASSIFY: begin
        if (feat_count < lrs_pkg::FEATURES) begin
          feat_buf[feat_count] = feature;
          feat_count++;
        end else begin
          overflow = 1'b1;
        end
        if (last) begin
          // dot product over the features actually held
          dot = 0;
          for (int i = 0; i < feat_count; i++) begin
            dot += longint'(weight_mem[i]) * longint'(feat_buf[i]);
          end
          if (dot < -LOGIT_CLAMP) begin
            idx = 0;
          end else if (dot >= LOGIT_CLAMP) begin
            idx = 255;
          end else begin
            idx = int'(((dot + LOGIT_CLAMP) >>> 32) & 64'sd255);
          end
          p        = sig_lut[idx];
          ans.prob = p;
          ans.wval = '0;
          ans.flag = overflow;
          owed_answers = {owed_answers, ans};
          // gradient step, rounded half up to Q.24, saturating
          if (func == lrs_pkg::FUNC_TRAIN) begin
            err    = longint'(label) * 65536 - longint'(p);
            scaled = longint'(rate) * err;
            for (int i = 0; i < feat_count; i++) begin
              delta = (scaled * longint'(feat_buf[i]) + HALF_LSB) >>> 28;
              sum   = longint'(weight_mem[i]) + delta;
              if (sum > W_MAX) begin
                weight_mem[i] = 32'sh7FFFFFFF;
              end else if (sum < W_MIN) begin
                weight_mem[i] = 32'sh80000000;
              end else begin
                weight_mem[i] = 32'(sum);
              end
            end
          end
          feat_count = 0;
          overflow   = 1'b0;
        end
      end
      default: ;  // unused code: ignored by the block
    endcase
  endtask

  task automatic check_answer();
    answer_t want;
    if (owed_answers.size() == 0) begin
      flag_fault($sformatf("unrequested result: prob %h weight %h flag %b",
                           probability, weight_value, too_many_features));
    end else begin
      want = owed_answers.pop_front();
      if (probability !== want.prob || weight_value !== want.wval ||
          too_many_features !== want.flag) begin
        flag_fault($sformatf(
          "result mismatch: prob %h/%h weight %h/%h flag %b/%b (want/got)",
          want.prob, probability, want.wval, weight_value, want.flag,
          too_many_features));
      end
    end
  endtask

  // Transfers are taken in channel order: result, item, register
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lrs_pkg::FEATURES; i++) begin
        weight_mem[i] = '0;
      end
      feat_count = 0;
      overflow   = 1'b0;
      rate       = lrs_pkg::LEARNING_RATE_RESET;
      owed_answers.delete();
    end else begin
      if (result_valid && result_ready) begin
        check_answer();
      end
      if (item_valid && item_ready) begin
        run_sgd_step();
      end
      if (psel && penable && pready && paddr == lrs_pkg::ADDR_LEARNING_RATE) begin
        if (pwrite) begin
          rate = pwdata[23:0];
        end else if (prdata !== {8'h00, rate}) begin
          flag_fault($sformatf("learning_rate read: want %h got %h",
                               {8'h00, rate}, prdata));
        end
      end
    end
    owed_count <= owed_answers.size();
  end

endmodule

### sim/tb_logistic_regression_sgd_step.sv
// Top of the testbench for logistic_regression_sgd_step: clock, reset, item and
// APB stimulus, result back-pressure and the verdict.
// Depends on lrs_pkg, the block itself and lrs_checker.
`timescale 1ns / 1ps

module tb_logistic_regression_sgd_step;

  localparam logic [1:0] FUNC_IDLE     = 2'd3;  // code the block ignores
  localparam int         SETTLE_CYCLES = 100;   // outlasts the busy time of any instance
  localparam int         HOLD_CYCLES   = 400;
  localparam int         PHASE_ITEMS   = 85;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic [1:0]         func;
  logic signed [15:0] feature;
  logic               label;
  logic               last;
  logic [3:0]         weight_index;
  logic               result_valid;
  logic               result_ready;
  logic [15:0]        probability;
  logic signed [31:0] weight_value;
  logic               too_many_features;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int answers_owed;
  int items_sent    = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  logistic_regression_sgd_step u_dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .func              (func),
    .feature           (feature),
    .label             (label),
    .last              (last),
    .weight_index      (weight_index),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .probability       (probability),
    .weight_value      (weight_value),
    .too_many_features (too_many_features),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  lrs_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .func              (func),
    .feature           (feature),
    .label             (label),
    .last              (last),
    .weight_index      (weight_index),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .probability       (probability),
    .weight_value      (weight_value),
    .too_many_features (too_many_features),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .mismatches        (mismatches),
    .answers_owed      (answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #5000000;
    $display("tb_logistic_regression_sgd_step: errors");
    $finish;
  end

  // Result side: random stall segments, plus long hold-offs on request
  initial begin
    int seg;
    int mode;
    result_ready = 1'b0;
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(1, 40);
        for (int c = 0; c < seg; c++) begin
          case (mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= (c % 4 == 3);
            default: result_ready <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic sender_idle(input int n);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One item transfer; bursts of random length with random gaps between them
  task automatic send(input logic [1:0] f, input logic signed [15:0] x,
                      input logic lb, input logic ls, input logic [3:0] wi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sender_idle(gap);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_valid   <= 1'b1;
    func         <= f;
    feature      <= x;
    label        <= lb;
    last         <= ls;
    weight_index <= wi;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (f != FUNC_IDLE) begin
      items_sent++;
    end
  endtask

  task automatic apb_access(input logic wr, input logic [23:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= lrs_pkg::ADDR_LEARNING_RATE;
    pwdata  <= {8'h00, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering, wait for every owed result, then let the block go idle
  task automatic drain();
    sender_idle(1);
    while (answers_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_feature();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Well-formed instance with random content; some overrun, some carry noise
  task automatic random_instance();
    int         len;
    logic [1:0] close_func;
    logic [1:0] f;
    len = ($urandom_range(0, 9) == 0) ?
          $urandom_range(lrs_pkg::FEATURES + 1, lrs_pkg::FEATURES + 4) :
          $urandom_range(1, lrs_pkg::FEATURES);
    close_func = ($urandom_range(0, 3) == 0) ? lrs_pkg::FUNC_CLASSIFY
                                             : lrs_pkg::FUNC_TRAIN;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        send(lrs_pkg::FUNC_READ, rand_feature(), 1'($urandom), 1'($urandom),
             4'($urandom));
      end
      if ($urandom_range(0, 39) == 0) begin
        send(FUNC_IDLE, rand_feature(), 1'($urandom), 1'($urandom), 4'($urandom));
      end
      f = (k == len - 1) ? close_func : 2'($urandom_range(0, 1));
      send(f, rand_feature(), 1'($urandom), k == len - 1, 4'($urandom));
    end
  endtask

  task automatic run_phase(input int budget, input bit with_hold, input bit with_pause);
    int start;
    int r;
    bit held;
    bit paused;
    start  = items_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - start < budget) begin
      if (with_hold && !held && items_sent - start >= budget / 4) begin
        hold_requests++;
        held = 1'b1;
      end
      if (with_pause && !paused && items_sent - start >= budget / 2) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(FUNC_IDLE, rand_feature(), 1'($urandom), 1'($urandom), 4'($urandom));
      end else if (r < 12) begin
        send(lrs_pkg::FUNC_READ, rand_feature(), 1'($urandom), 1'($urandom),
             4'($urandom));
      end else begin
        random_instance();
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic [23:0] rates [5];
    item_valid   = 1'b0;
    func         = lrs_pkg::FUNC_TRAIN;
    feature      = '0;
    label        = 1'b0;
    last         = 1'b0;
    weight_index = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = lrs_pkg::ADDR_LEARNING_RATE;
    pwdata       = '0;
    rst          = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, '0);

    // Directed: reads of fresh weights, ignored code, short training
    // instance with extreme features, one-feature classify, and an
    // overrunning instance with a read in the middle
    send(lrs_pkg::FUNC_READ, 16'sh0000, 1'b0, 1'b0, 4'd0);
    send(FUNC_IDLE, 16'sh5A5A, 1'b1, 1'b1, 4'd15);
    send(lrs_pkg::FUNC_TRAIN, 16'sh7FFF, 1'b0, 1'b0, 4'd0);
    send(lrs_pkg::FUNC_CLASSIFY, 16'sh8000, 1'b0, 1'b0, 4'd0);
    send(lrs_pkg::FUNC_TRAIN, 16'sh1000, 1'b1, 1'b1, 4'd0);
    send(lrs_pkg::FUNC_READ, 16'sh0000, 1'b0, 1'b0, 4'd15);
    send(lrs_pkg::FUNC_CLASSIFY, 16'sh8000, 1'b0, 1'b1, 4'd0);
    for (int k = 0; k <= lrs_pkg::FEATURES; k++) begin
      if (k == 8) begin
        send(lrs_pkg::FUNC_READ, 16'sh0000, 1'b0, 1'b0, 4'd2);
      end
      send(lrs_pkg::FUNC_TRAIN, (k % 2 == 0) ? 16'sh7FFF : 16'sh8000, 1'b0,
           k == lrs_pkg::FEATURES, 4'd0);
    end
    drain();

    // Random phases, each under its own step size, extremes first
    rates[0] = 24'hFFFFFF;
    rates[1] = 24'h000000;
    rates[2] = 24'($urandom_range(0, 24'hFFFFFF));
    rates[3] = 24'($urandom_range(24'h100000, 24'hFFFFFF));
    rates[4] = 24'($urandom_range(0, 24'h00FFFF));
    for (int ph = 0; ph < 5; ph++) begin
      apb_access(1'b1, rates[ph]);
      apb_access(1'b0, '0);
      run_phase(PHASE_ITEMS, ph == 0 || ph == 3, ph == 2);
      drain();
    end

    if (mismatches == 0 && answers_owed == 0) begin
      $display("tb_logistic_regression_sgd_step: clean");
    end else begin
      $display("tb_logistic_regression_sgd_step: errors");
    end
    $finish;
  end

endmodule
